FILE: rtl/rhw_pkg.sv
// ----------------------------------------------------------------------------
// rhw_pkg: shared definitions for the robust Holt-Winters smoother
// Ring sizing, register indexes, the control word of the iterative
// divide / square-root unit and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package rhw_pkg;

   // Seasonal ring sizing.
   localparam int SEASON_MAX = 64;
   localparam int RING_AW    = (SEASON_MAX > 1) ? $clog2(SEASON_MAX) : 1;
   localparam int LEN_W      = $clog2(SEASON_MAX + 1);

   // Configuration register indexes.
   localparam logic [2:0] CSR_ALPHA      = 3'd0;
   localparam logic [2:0] CSR_BETA       = 3'd1;
   localparam logic [2:0] CSR_GAMMA      = 3'd2;
   localparam logic [2:0] CSR_SEASON_LEN = 3'd3;
   localparam logic [2:0] CSR_LEVEL_INIT = 3'd4;
   localparam logic [2:0] CSR_TREND_INIT = 3'd5;
   localparam logic [2:0] CSR_SIGMA_INIT = 3'd6;
   localparam logic [2:0] CSR_SKIP       = 3'd7;

   // Control word of the shared divide / square-root unit.
   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } iter_ctl_type;

   // Saturate a wide signed value to 32 signed bits.
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [67:0] hi;
      logic signed [67:0] lo;
      hi = 68'sd2147483647;
      lo = -68'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

FILE: rtl/rhw_if.sv
// ----------------------------------------------------------------------------
// rhw_if: channel interfaces of the robust Holt-Winters smoother
// Sample channel, result channel and register write channel, each with
// valid / ready and its payload.
// ----------------------------------------------------------------------------
interface rhw_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] value;
   modport source (output valid, cmd, value, input ready);
   modport sink   (input valid, cmd, value, output ready);
endinterface

interface rhw_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] forecast;
   logic signed [31:0] cleaned_sample;
   logic               was_clipped;
   logic signed [31:0] new_level;
   logic signed [31:0] new_trend;
   logic signed [31:0] new_season;
   logic [30:0]        new_sigma;
   logic [62:0]        sse_total;
   modport source (output valid, forecast, cleaned_sample, was_clipped, new_level,
                   new_trend, new_season, new_sigma, sse_total, input ready);
   modport sink   (input valid, forecast, cleaned_sample, was_clipped, new_level,
                   new_trend, new_season, new_sigma, sse_total, output ready);
endinterface

interface rhw_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rhw_ram.sv
// ----------------------------------------------------------------------------
// rhw_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rhw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rhw_iter.sv
// ----------------------------------------------------------------------------
// rhw_iter: shared restoring divide / square-root unit
// One compare-and-subtract per cycle. Divide mode gives (num << 30) / den
// for num <= den; square-root mode gives floor(sqrt(num << 30)).
// ----------------------------------------------------------------------------
module rhw_iter import rhw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_ctl_type ctl,
   input  logic [31:0]  num,
   input  logic [31:0]  den,
   output logic         busy,
   output logic [30:0]  res
);

   localparam int STEPS = 31;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        mode_ff, mode_in;
   logic [32:0] rem_ff, rem_in;
   logic [61:0] sh_ff, sh_in;
   logic [31:0] den_ff, den_in;
   logic [30:0] res_ff, res_in;

   logic [34:0] cand;
   logic [34:0] trial;
   logic [34:0] diff;
   logic        ge;

   // One restoring step: bring in the next digit, try the subtraction.
   always_comb begin
      cand  = mode_ff ? {rem_ff, sh_ff[61:60]} : {1'b0, rem_ff, sh_ff[61]};
      trial = mode_ff ? {2'b00, res_ff, 2'b01} : {3'b000, den_ff};
      diff  = cand - trial;
      ge    = (cand >= trial);

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      res_in  = res_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mode_in = ctl.sqrt_mode;
         den_in  = den;
         res_in  = '0;
         if (ctl.sqrt_mode) begin
            rem_in = '0;
            sh_in  = {num, 30'd0};
         end else begin
            rem_in = {2'b00, num[31:1]};
            sh_in  = {num[0], 61'd0};
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : cand[32:0];
         res_in = {res_ff[29:0], ge};
         sh_in  = mode_ff ? {sh_ff[59:0], 2'b00} : {sh_ff[60:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
   end

   assign busy = busy_ff;
   assign res  = res_ff;

endmodule

FILE: rtl/robust_holt_winters_update.sv
// ----------------------------------------------------------------------------
// robust_holt_winters_update: robust additive Holt-Winters smoother
// Clips outlier residuals at two sigma, smooths level, trend and season,
// rescales sigma with a capped biweight loss and keeps a saturating SSE.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Payload
//  req_ch    in         valid/ready   cmd, value
//  rsp_ch    out        valid/ready   forecast ... sse_total
//  csr_ch    in         valid/ready   index, data (always ready)
//
// A seed item or a skipped sample is taken without leaving the idle state. A
// processed sample holds the input not ready until its result is committed,
// so a new sample is taken only once the last is through: a 31-step divide and
// a 31-step square root in the shared iterative unit, ten multiplies on the one
// shared multiplier and the steps between them. The divide overlaps the nine
// smoothing steps. The result item is presented from a register once it commits.
// Reset is synchronous; the ring content is undefined until written.
// The block waits in its last step while an earlier result is not yet taken.
// ----------------------------------------------------------------------------
module robust_holt_winters_update import rhw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rhw_req_if.sink   req_ch,
   rhw_rsp_if.source rsp_ch,
   rhw_csr_if.sink   csr_ch
);

   // Sequencer codes.
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_FCST = 5'd1;
   localparam logic [4:0] S_RES  = 5'd2;
   localparam logic [4:0] S_CLIP = 5'd3;
   localparam logic [4:0] S_SQ   = 5'd4;
   localparam logic [4:0] S_SSE  = 5'd5;
   localparam logic [4:0] S_LMUL = 5'd6;
   localparam logic [4:0] S_LRND = 5'd7;
   localparam logic [4:0] S_TPRE = 5'd8;
   localparam logic [4:0] S_TMUL = 5'd9;
   localparam logic [4:0] S_TRND = 5'd10;
   localparam logic [4:0] S_SPRE = 5'd11;
   localparam logic [4:0] S_SMUL = 5'd12;
   localparam logic [4:0] S_SRND = 5'd13;
   localparam logic [4:0] S_DIV  = 5'd14;
   localparam logic [4:0] S_W    = 5'd15;
   localparam logic [4:0] S_Q    = 5'd16;
   localparam logic [4:0] S_QQ   = 5'd17;
   localparam logic [4:0] S_QQQ  = 5'd18;
   localparam logic [4:0] S_F    = 5'd19;
   localparam logic [4:0] S_RHO  = 5'd20;
   localparam logic [4:0] S_MD   = 5'd21;
   localparam logic [4:0] S_MADD = 5'd22;
   localparam logic [4:0] S_SQRT = 5'd23;
   localparam logic [4:0] S_NS   = 5'd24;
   localparam logic [4:0] S_FIN  = 5'd25;

   // Fixed-point constants.
   localparam logic [30:0] ONE_Q30        = 31'h40000000;
   localparam logic [31:0] CK_Q30         = 32'd2705829396;
   localparam logic [27:0] DELTA_Q30      = 28'd214748365;
   localparam logic [31:0] ONE_LESS_DELTA = 32'd858993459;
   localparam logic [16:0] GAIN_ONE       = 17'd65536;
   localparam logic [62:0] SSE_MAX        = {63{1'b1}};
   localparam logic [30:0] SIGMA_MAX      = {31{1'b1}};

   // Control and configuration state.
   logic [4:0]          state_ff, state_in;
   logic [16:0]         alpha_ff, alpha_in, beta_ff, beta_in, gamma_ff, gamma_in;
   logic [6:0]          slen_ff, slen_in;
   logic [15:0]         skip_lim_ff, skip_lim_in, skip_ff, skip_in;
   logic [RING_AW-1:0]  ptr_ff, ptr_in, p_ff, p_in, pn_ff, pn_in;
   logic signed [31:0]  level_ff, level_in, trend_ff, trend_in;
   logic [30:0]         sigma_ff, sigma_in;
   logic [62:0]         sse_ff, sse_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers of one sample.
   logic signed [31:0]  x_ff, x_in, s_ff, s_in, xhat_ff, xhat_in, clean_ff, clean_in;
   logic signed [31:0]  ln_ff, ln_in, tn_ff, tn_in, sn_ff, sn_in;
   logic signed [32:0]  r_ff, r_in, b_ff, b_in;
   logic signed [34:0]  d_ff, d_in;
   logic [31:0]         mag_ff, mag_in;
   logic                clip_ff, clip_in;
   logic signed [67:0]  prod_ff, prod_in;
   logic [30:0]         q_ff, q_in, t_ff, t_in;

   // Result register.
   logic signed [31:0]  o_fcst_ff, o_fcst_in, o_clean_ff, o_clean_in;
   logic                o_clip_ff, o_clip_in;
   logic signed [31:0]  o_lvl_ff, o_lvl_in, o_trd_ff, o_trd_in, o_sea_ff, o_sea_in;
   logic [30:0]         o_sig_ff, o_sig_in;
   logic [62:0]         o_sse_ff, o_sse_in;

   // Combinational helpers.
   logic [LEN_W-1:0]    len;
   logic [RING_AW-1:0]  p_cur, p_nxt;
   logic [16:0]         ka, kb, kg;
   logic                req_acc;
   logic signed [32:0]  mul_a;
   logic signed [34:0]  mul_b;
   logic signed [67:0]  sm_sum, sm_rnd;
   logic signed [31:0]  sm_val;
   logic [32:0]         abs_r;
   logic [31:0]         lim;
   logic [63:0]         sq_sum;
   logic [62:0]         sq_c;
   logic [62:0]         ns_sum;
   logic [31:0]         m_val;
   iter_ctl_type        iter_ctl;
   logic [31:0]         iter_num, iter_den;
   logic                iter_busy;
   logic [30:0]         iter_res;

   logic                ram_we;
   logic [RING_AW-1:0]  ram_waddr;
   logic [31:0]         ram_wdata, ram_rdata;

   rhw_ram #(.WIDTH(32), .DEPTH(SEASON_MAX)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (p_cur),
      .rd_data (ram_rdata)
   );

   rhw_iter u_iter (
      .clock (clock),
      .reset (reset),
      .ctl   (iter_ctl),
      .num   (iter_num),
      .den   (iter_den),
      .busy  (iter_busy),
      .res   (iter_res)
   );

   // Effective gains, season length and ring positions.
   always_comb begin
      ka = (alpha_ff > GAIN_ONE) ? GAIN_ONE : alpha_ff;
      kb = (beta_ff > GAIN_ONE) ? GAIN_ONE : beta_ff;
      kg = (gamma_ff > GAIN_ONE) ? GAIN_ONE : gamma_ff;
      if (slen_ff == 7'd0) begin
         len = LEN_W'(1);
      end else if (int'(slen_ff) > SEASON_MAX) begin
         len = LEN_W'(SEASON_MAX);
      end else begin
         len = LEN_W'(slen_ff);
      end
      p_cur = (LEN_W'(ptr_ff) < len) ? ptr_ff : '0;
      p_nxt = ((LEN_W'(p_cur) + LEN_W'(1)) >= len) ? '0 : p_cur + RING_AW'(1);
   end

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {3'b000, mag_ff};
         end
         S_LMUL: begin
            mul_a = {16'd0, ka};
            mul_b = d_ff;
         end
         S_TMUL: begin
            mul_a = {16'd0, kb};
            mul_b = d_ff;
         end
         S_SMUL: begin
            mul_a = {16'd0, kg};
            mul_b = d_ff;
         end
         S_W: begin
            mul_a = {2'b00, iter_res};
            mul_b = {4'd0, iter_res};
         end
         S_QQ: begin
            mul_a = {2'b00, q_ff};
            mul_b = {4'd0, q_ff};
         end
         S_QQQ: begin
            mul_a = {2'b00, prod_ff[60:30]};
            mul_b = {4'd0, q_ff};
         end
         S_RHO: begin
            mul_a = {1'b0, CK_Q30};
            mul_b = {4'd0, t_ff};
         end
         S_MD: begin
            mul_a = {5'd0, DELTA_Q30};
            mul_b = {3'b000, prod_ff[61:30]};
         end
         // The sigma product stays in place while the result waits.
         S_NS, S_FIN: begin
            mul_a = {2'b00, sigma_ff};
            mul_b = {4'd0, iter_res};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 68'(mul_a) * 68'(mul_b);
   end

   // Shared arithmetic read by several steps.
   always_comb begin
      // Smoothing: b * 65536 + k * (a - b), rounded half away from zero.
      sm_sum = prod_ff + ({{35{b_ff[32]}}, b_ff} <<< 16);
      if (sm_sum[67]) begin
         sm_rnd = -((-sm_sum + 68'sd32768) >>> 16);
      end else begin
         sm_rnd = (sm_sum + 68'sd32768) >>> 16;
      end
      sm_val = sat32(sm_rnd);

      lim   = {sigma_ff, 1'b0};
      abs_r = r_ff[32] ? 33'(-r_ff) : 33'(r_ff);

      // Squared residual, saturated into the running sum.
      sq_c   = prod_ff[63] ? SSE_MAX : prod_ff[62:0];
      sq_sum = {1'b0, sse_ff} + {1'b0, sq_c};

      ns_sum = {1'b0, prod_ff[61:0]} + 63'd536870912;
      m_val  = prod_ff[61:30] + ONE_LESS_DELTA;
   end

   // Sequencer and datapath.
   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      gamma_in     = gamma_ff;
      slen_in      = slen_ff;
      skip_lim_in  = skip_lim_ff;
      skip_in      = skip_ff;
      ptr_in       = ptr_ff;
      p_in         = p_ff;
      pn_in        = pn_ff;
      level_in     = level_ff;
      trend_in     = trend_ff;
      sigma_in     = sigma_ff;
      sse_in       = sse_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      x_in     = x_ff;
      s_in     = s_ff;
      xhat_in  = xhat_ff;
      clean_in = clean_ff;
      ln_in    = ln_ff;
      tn_in    = tn_ff;
      sn_in    = sn_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      mag_in   = mag_ff;
      clip_in  = clip_ff;
      q_in     = q_ff;
      t_in     = t_ff;

      o_fcst_in  = o_fcst_ff;
      o_clean_in = o_clean_ff;
      o_clip_in  = o_clip_ff;
      o_lvl_in   = o_lvl_ff;
      o_trd_in   = o_trd_ff;
      o_sea_in   = o_sea_ff;
      o_sig_in   = o_sig_ff;
      o_sse_in   = o_sse_ff;

      ram_we    = 1'b0;
      ram_waddr = p_cur;
      ram_wdata = req_ch.value;

      iter_ctl = '0;
      iter_num = '0;
      iter_den = '0;

      req_acc = req_ch.valid && (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (!req_ch.cmd) begin
                  // Seed item: fill the ring slot and move on.
                  ram_we = 1'b1;
                  ptr_in = p_nxt;
               end else if (skip_ff < skip_lim_ff) begin
                  skip_in = skip_ff + 16'd1;
               end else begin
                  x_in     = req_ch.value;
                  p_in     = p_cur;
                  pn_in    = p_nxt;
                  state_in = S_FCST;
               end
            end
         end
         S_FCST: begin
            s_in    = ram_rdata;
            xhat_in = sat32(68'(level_ff) + 68'(trend_ff) + 68'(signed'(ram_rdata)));
            state_in = S_RES;
         end
         S_RES: begin
            r_in     = 33'(x_ff) - 33'(xhat_ff);
            state_in = S_CLIP;
         end
         S_CLIP: begin
            // Residual beyond two sigma is clipped and the sample replaced.
            clip_in = (abs_r > {1'b0, lim});
            if (abs_r > {1'b0, lim}) begin
               mag_in = lim;
               if (r_ff[32]) begin
                  clean_in = sat32(68'(xhat_ff) - 68'(lim));
               end else begin
                  clean_in = sat32(68'(xhat_ff) + 68'(lim));
               end
            end else begin
               mag_in   = abs_r[31:0];
               clean_in = x_ff;
            end
            state_in = S_SQ;
         end
         S_SQ: begin
            iter_ctl.start     = 1'b1;
            iter_ctl.sqrt_mode = 1'b0;
            iter_num           = mag_ff;
            iter_den           = lim;
            state_in           = S_SSE;
         end
         S_SSE: begin
            sse_in   = sq_sum[63] ? SSE_MAX : sq_sum[62:0];
            b_in     = 33'(level_ff) + 33'(trend_ff);
            d_in     = 35'(clean_ff) - 35'(s_ff) - 35'(level_ff) - 35'(trend_ff);
            state_in = S_LMUL;
         end
         S_LMUL: begin
            state_in = S_LRND;
         end
         S_LRND: begin
            ln_in    = sm_val;
            state_in = S_TPRE;
         end
         S_TPRE: begin
            b_in     = 33'(trend_ff);
            d_in     = 35'(ln_ff) - 35'(level_ff) - 35'(trend_ff);
            state_in = S_TMUL;
         end
         S_TMUL: begin
            state_in = S_TRND;
         end
         S_TRND: begin
            tn_in    = sm_val;
            state_in = S_SPRE;
         end
         S_SPRE: begin
            b_in     = 33'(s_ff);
            d_in     = 35'(clean_ff) - 35'(ln_ff) - 35'(s_ff);
            state_in = S_SMUL;
         end
         S_SMUL: begin
            state_in = S_SRND;
         end
         S_SRND: begin
            sn_in    = sm_val;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!iter_busy) begin
               state_in = S_W;
            end
         end
         S_W: begin
            state_in = S_Q;
         end
         S_Q: begin
            q_in     = ONE_Q30 - prod_ff[60:30];
            state_in = S_QQ;
         end
         S_QQ: begin
            state_in = S_QQQ;
         end
         S_QQQ: begin
            state_in = S_F;
         end
         S_F: begin
            t_in     = ONE_Q30 - prod_ff[60:30];
            state_in = S_RHO;
         end
         S_RHO: begin
            state_in = S_MD;
         end
         S_MD: begin
            state_in = S_MADD;
         end
         S_MADD: begin
            iter_ctl.start     = 1'b1;
            iter_ctl.sqrt_mode = 1'b1;
            iter_num           = m_val;
            state_in           = S_SQRT;
         end
         S_SQRT: begin
            if (!iter_busy) begin
               state_in = S_NS;
            end
         end
         S_NS: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            // Commit the new state and hand the result to the output register.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               if (ns_sum[62:30] == 33'd0) begin
                  sigma_in = 31'd1;
               end else if (ns_sum[62:61] != 2'b00) begin
                  sigma_in = SIGMA_MAX;
               end else begin
                  sigma_in = ns_sum[60:30];
               end
               level_in     = ln_ff;
               trend_in     = tn_ff;
               ram_we       = 1'b1;
               ram_waddr    = p_ff;
               ram_wdata    = sn_ff;
               ptr_in       = pn_ff;
               o_fcst_in    = xhat_ff;
               o_clean_in   = clean_ff;
               o_clip_in    = clip_ff;
               o_lvl_in     = ln_ff;
               o_trd_in     = tn_ff;
               o_sea_in     = sn_ff;
               o_sig_in     = sigma_in;
               o_sse_in     = sse_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes are to arrive only while the block is idle; the block does not enforce it.
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ALPHA:      alpha_in = csr_ch.data[16:0];
            CSR_BETA:       beta_in  = csr_ch.data[16:0];
            CSR_GAMMA:      gamma_in = csr_ch.data[16:0];
            CSR_SEASON_LEN: begin
               slen_in = csr_ch.data[6:0];
               ptr_in  = '0;
            end
            CSR_LEVEL_INIT: level_in = csr_ch.data;
            CSR_TREND_INIT: trend_in = csr_ch.data;
            CSR_SIGMA_INIT: begin
               sigma_in = (csr_ch.data[30:0] == 31'd0) ? 31'd1 : csr_ch.data[30:0];
            end
            CSR_SKIP: begin
               skip_lim_in = csr_ch.data[15:0];
               skip_in     = '0;
            end
            default: begin
               alpha_in = alpha_ff;
            end
         endcase
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_ff     <= 17'd32768;
         beta_ff      <= 17'd6554;
         gamma_ff     <= 17'd6554;
         slen_ff      <= 7'd12;
         skip_lim_ff  <= '0;
         skip_ff      <= '0;
         ptr_ff       <= '0;
         level_ff     <= '0;
         trend_ff     <= '0;
         sigma_ff     <= 31'd65536;
         sse_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         gamma_ff     <= gamma_in;
         slen_ff      <= slen_in;
         skip_lim_ff  <= skip_lim_in;
         skip_ff      <= skip_in;
         ptr_ff       <= ptr_in;
         level_ff     <= level_in;
         trend_ff     <= trend_in;
         sigma_ff     <= sigma_in;
         sse_ff       <= sse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      pn_ff      <= pn_in;
      x_ff       <= x_in;
      s_ff       <= s_in;
      xhat_ff    <= xhat_in;
      clean_ff   <= clean_in;
      ln_ff      <= ln_in;
      tn_ff      <= tn_in;
      sn_ff      <= sn_in;
      r_ff       <= r_in;
      b_ff       <= b_in;
      d_ff       <= d_in;
      mag_ff     <= mag_in;
      clip_ff    <= clip_in;
      prod_ff    <= prod_in;
      q_ff       <= q_in;
      t_ff       <= t_in;
      o_fcst_ff  <= o_fcst_in;
      o_clean_ff <= o_clean_in;
      o_clip_ff  <= o_clip_in;
      o_lvl_ff   <= o_lvl_in;
      o_trd_ff   <= o_trd_in;
      o_sea_ff   <= o_sea_in;
      o_sig_ff   <= o_sig_in;
      o_sse_ff   <= o_sse_in;
   end

   // Port drive.
   assign req_ch.ready          = (state_ff == S_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.forecast       = o_fcst_ff;
   assign rsp_ch.cleaned_sample = o_clean_ff;
   assign rsp_ch.was_clipped    = o_clip_ff;
   assign rsp_ch.new_level      = o_lvl_ff;
   assign rsp_ch.new_trend      = o_trd_ff;
   assign rsp_ch.new_season     = o_sea_ff;
   assign rsp_ch.new_sigma      = o_sig_ff;
   assign rsp_ch.sse_total      = o_sse_ff;

endmodule
